// File: hdl/nlc_pkg.sv
`default_nettype none
package nlc_pkg;

  localparam int CMD_W   = 2;
  localparam int ZOOM_W  = 5;
  localparam int TILE_W  = 24;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 4;

  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [ZOOM_W-1:0] zoom;
    logic [TILE_W-1:0] col;
    logic [TILE_W-1:0] row;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic load;   // capture request, clear walk state
    logic walk;   // issue one read, evaluate the previous one
    logic write;  // commit record into the chosen slot
    logic emit;   // move result into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_walk;  // incoming request has work to do
    logic is_record;  // captured request is a record
    logic done;       // walk finished this cycle
  } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/ttl_negative_lookup_cache.sv
// Negative lookup cache: holds up to ENTRIES failed tile keys with the time
// each one failed, and answers whether a key failed within the lifetime.
// Input channel (in_valid/in_ready) carries one request: cmd, key
// (zoom, tile_x, tile_y) and now_ms. Output channel (out_valid/out_ready)
// carries one response per request: hit for query, live_count for count.
// ttl_ms is loaded with ttl_ms_we; write it only while the block is idle.
// Each request is captured, then walks the entry memory (one read and one
// write port), one entry read per cycle with a registered read; a record
// then writes its chosen slot, and the result moves into the output
// register. Query and count with a zero lifetime, and the unused command,
// skip the walk. Query stops at the first live hit.
// One request is in flight at a time; in_ready is high only when idle.
// The output register is separate, so a new request is taken while a
// response waits; a stalled receiver then holds the next response back.
// Reset clears all valid bits and the lifetime; no clearing pass is needed.
`default_nettype none
module ttl_negative_lookup_cache #(
  parameter int ENTRIES = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        ttl_ms_we,
  input  wire logic [nlc_pkg::TIME_W-1:0]  ttl_ms,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [nlc_pkg::CMD_W-1:0]   cmd,
  input  wire logic [nlc_pkg::ZOOM_W-1:0]  zoom,
  input  wire logic [nlc_pkg::TILE_W-1:0]  tile_x,
  input  wire logic [nlc_pkg::TILE_W-1:0]  tile_y,
  input  wire logic [nlc_pkg::TIME_W-1:0]  now_ms,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             hit,
  output logic      [nlc_pkg::COUNT_W-1:0] live_count
);

  nlc_pkg::ctrl_cmd_t  ctl;
  nlc_pkg::dp_status_t st;

  nlc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (ctl)
  );

  nlc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ttl_ms_we  (ttl_ms_we),
    .ttl_ms     (ttl_ms),
    .cmd        (cmd),
    .zoom       (zoom),
    .tile_x     (tile_x),
    .tile_y     (tile_y),
    .now_ms     (now_ms),
    .hit        (hit),
    .live_count (live_count),
    .ctl        (ctl),
    .st         (st)
  );

endmodule
`default_nettype wire

// File: hdl/nlc_ram.sv
`default_nettype none
module nlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/nlc_ctrl.sv
`default_nettype none
module nlc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire nlc_pkg::dp_status_t st,
  output nlc_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == S_IDLE) && in_valid;
    cmd.walk  = (state == S_WALK);
    cmd.write = (state == S_WRITE);
    cmd.emit  = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // hold a stalled response, load a new one when the register frees up
      out_valid <= (out_valid && !out_ready) || ((state == S_FINISH) && out_free);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= st.need_walk ? S_WALK : S_FINISH;
          end
        end
        S_WALK: begin
          if (st.done) begin
            state <= st.is_record ? S_WRITE : S_FINISH;
          end
        end
        S_WRITE: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register can take the result
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/nlc_dp.sv
`default_nettype none
module nlc_dp #(
  parameter int ENTRIES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          ttl_ms_we,
  input  wire logic [nlc_pkg::TIME_W-1:0]    ttl_ms,
  input  wire logic [nlc_pkg::CMD_W-1:0]     cmd,
  input  wire logic [nlc_pkg::ZOOM_W-1:0]    zoom,
  input  wire logic [nlc_pkg::TILE_W-1:0]    tile_x,
  input  wire logic [nlc_pkg::TILE_W-1:0]    tile_y,
  input  wire logic [nlc_pkg::TIME_W-1:0]    now_ms,
  output logic                               hit,
  output logic      [nlc_pkg::COUNT_W-1:0]   live_count,
  input  wire nlc_pkg::ctrl_cmd_t            ctl,
  output nlc_pkg::dp_status_t                st
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  logic [nlc_pkg::TIME_W-1:0]  ttl;
  logic [nlc_pkg::CMD_W-1:0]   req_cmd;
  logic [nlc_pkg::ZOOM_W-1:0]  req_zoom;
  logic [nlc_pkg::TILE_W-1:0]  req_col;
  logic [nlc_pkg::TILE_W-1:0]  req_row;
  logic [nlc_pkg::TIME_W-1:0]  req_now;

  logic [ENTRIES-1:0]          valid;
  logic [IW-1:0]               issue_idx;
  logic [IW-1:0]               ev_idx;
  logic                        ev_vld;

  logic                        hit_r;
  logic [nlc_pkg::COUNT_W-1:0] cnt_r;
  logic                        found;
  logic [IW-1:0]               found_idx;
  logic                        have_empty;
  logic [IW-1:0]               empty_idx;
  logic [IW-1:0]               victim_idx;
  logic [nlc_pkg::TIME_W-1:0]  victim_age;

  logic [nlc_pkg::ENTRY_W-1:0] rdata;
  nlc_pkg::entry_t             ent;
  nlc_pkg::entry_t             wr_ent;
  logic [IW-1:0]               slot;
  logic [nlc_pkg::TIME_W-1:0]  age;
  logic                        ev_v;
  logic                        expired;
  logic                        match;
  logic                        is_query;
  logic                        is_count;
  logic                        is_record;

  assign ent       = nlc_pkg::entry_t'(rdata);
  assign ev_v      = ev_vld && valid[ev_idx];
  assign age       = req_now - ent.stamp;
  assign expired   = (age >= ttl);
  assign match     = (ent.zoom == req_zoom) && (ent.col == req_col) && (ent.row == req_row);
  assign is_query  = (req_cmd == nlc_pkg::CMD_QUERY);
  assign is_count  = (req_cmd == nlc_pkg::CMD_COUNT);
  assign is_record = (req_cmd == nlc_pkg::CMD_RECORD);

  assign slot = found ? found_idx : (have_empty ? empty_idx : victim_idx);

  always_comb begin
    wr_ent       = '0;
    wr_ent.zoom  = req_zoom;
    wr_ent.col   = req_col;
    wr_ent.row   = req_row;
    wr_ent.stamp = req_now;
  end

  always_comb begin
    st           = '0;
    st.need_walk = (cmd == nlc_pkg::CMD_RECORD) ||
                   (((cmd == nlc_pkg::CMD_QUERY) || (cmd == nlc_pkg::CMD_COUNT)) && (ttl != '0));
    st.is_record = is_record;
    // stop early on a live query hit or a record match
    st.done      = ev_vld && ((ev_idx == LAST_IDX) ||
                   (ev_v && is_query && !expired && match) ||
                   (ev_v && is_record && match));
  end

  nlc_ram #(
    .WIDTH (nlc_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.write),
    .waddr (slot),
    .wdata (wr_ent),
    .raddr (issue_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl    <= '0;
      valid  <= '0;
      ev_vld <= 1'b0;
    end else begin
      if (ttl_ms_we) begin
        ttl <= ttl_ms;
      end
      // drop the read still in flight once the walk stops
      ev_vld <= ctl.walk && !st.done;
      if (ev_v && (is_query || is_count) && expired) begin
        valid[ev_idx] <= 1'b0;
      end
      if (ctl.write) begin
        valid[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd    <= cmd;
      req_zoom   <= zoom;
      req_col    <= tile_x;
      req_row    <= tile_y;
      req_now    <= now_ms;
      issue_idx  <= '0;
      ev_idx     <= '0;
      hit_r      <= 1'b0;
      cnt_r      <= '0;
      found      <= 1'b0;
      found_idx  <= '0;
      have_empty <= 1'b0;
      empty_idx  <= '0;
      victim_idx <= '0;
      victim_age <= '0;
    end else begin
      if (ctl.walk) begin
        ev_idx <= issue_idx;
        if (issue_idx != LAST_IDX) begin
          issue_idx <= issue_idx + 1'b1;
        end
      end
      if (ev_vld) begin
        if (is_query && ev_v && !expired && match) begin
          hit_r <= 1'b1;
        end
        if (is_count && ev_v && !expired && (cnt_r != nlc_pkg::COUNT_MAX)) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (is_record && !found) begin
          if (ev_v && match) begin
            found     <= 1'b1;
            found_idx <= ev_idx;
          end else if (!ev_v) begin
            if (!have_empty) begin
              have_empty <= 1'b1;
              empty_idx  <= ev_idx;
            end
          end else if (age > victim_age) begin
            victim_idx <= ev_idx;
            victim_age <= age;
          end
        end
      end
    end
    if (ctl.emit) begin
      hit        <= hit_r;
      live_count <= cnt_r;
    end
  end

endmodule
`default_nettype wire

// File: hdl/nlc_checker.sv
`default_nettype none
module nlc_checker #(
  parameter int ENTRIES = 8
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        hit,
  input wire logic [nlc_pkg::COUNT_W-1:0] live_count
);

  // stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(live_count))
    else $error("response changed while stalled");

  // one request in flight: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while walking");

  // a response is either a hit or a count, never both
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && (live_count != '0)))
    else $error("hit and count both set");

  // count never exceeds the number of entries
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(live_count) <= ENTRIES))
    else $error("live count above capacity");

endmodule

bind ttl_negative_lookup_cache nlc_checker #(.ENTRIES(ENTRIES)) u_nlc_checker (.*);
`default_nettype wire

// File: verif/tb_ttl_negative_lookup_cache.sv
`timescale 1ns / 100ps

module tb_ttl_negative_lookup_cache;
  import nlc_pkg::*;

  localparam int ENTRIES = 8;
  localparam int KEY_POOL = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_LONG_HOLD = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [ZOOM_W-1:0] zoom;
    logic [TILE_W-1:0] col;
    logic [TILE_W-1:0] row;
  } tile_key_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ZOOM_W-1:0] zoom;
    logic [TILE_W-1:0] col;
    logic [TILE_W-1:0] row;
    logic [TIME_W-1:0] now;
  } lookup_req_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] live_count;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic ttl_ms_we = 1'b0;
  logic [TIME_W-1:0] ttl_ms = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [ZOOM_W-1:0] zoom = '0;
  logic [TILE_W-1:0] tile_x = '0;
  logic [TILE_W-1:0] tile_y = '0;
  logic [TIME_W-1:0] now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic [COUNT_W-1:0] live_count;

  // shadow copy of the cache contents and lifetime
  logic [TIME_W-1:0] lifetime_ms = '0;
  bit                cache_valid [ENTRIES];
  logic [ZOOM_W-1:0] cache_zoom [ENTRIES];
  logic [TILE_W-1:0] cache_col [ENTRIES];
  logic [TILE_W-1:0] cache_row [ENTRIES];
  logic [TIME_W-1:0] cache_stamp [ENTRIES];

  lookup_req_t req_queue[$];
  answer_t     answers_due[$];
  tile_key_t   key_pool [KEY_POOL];

  int issued = 0;
  int answered = 0;
  int errors = 0;
  int stall_cycles = 0;
  bit in_taken = 1'b0;

  int tx_gap = 0;
  int tx_free = 0;
  bit tx_drain = 1'b0;
  int rx_wait = 0;
  int rx_free = 0;
  int next_long_hold = 300;

  logic [TIME_W-1:0] clock_ms;
  logic [TIME_W-1:0] phase_ttl;

  ttl_negative_lookup_cache #(
    .ENTRIES (ENTRIES)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .ttl_ms_we  (ttl_ms_we),
    .ttl_ms     (ttl_ms),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .zoom       (zoom),
    .tile_x     (tile_x),
    .tile_y     (tile_y),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .live_count (live_count)
  );

  always #4 clk = ~clk;

  function automatic logic key_match(int i, lookup_req_t r);
    return cache_zoom[i] == r.zoom && cache_col[i] == r.col && cache_row[i] == r.row;
  endfunction

  task automatic predict_answer(input lookup_req_t r, output answer_t a);
    int i;
    int empty_slot;
    int victim;
    logic [TIME_W-1:0] victim_age;
    logic [TIME_W-1:0] age;
    bit refreshed;
    int live;
    a = '0;
    live = 0;
    case (r.cmd)
      CMD_QUERY: begin
        if (lifetime_ms != 0) begin
          for (i = 0; i < ENTRIES; i++) begin
            if (!cache_valid[i]) continue;
            age = r.now - cache_stamp[i];
            if (age >= lifetime_ms) begin
              cache_valid[i] = 1'b0;
              continue;
            end
            // stop at the first live match, later entries keep their state
            if (key_match(i, r)) begin
              a.hit = 1'b1;
              break;
            end
          end
        end
      end
      CMD_RECORD: begin
        empty_slot = -1;
        victim = 0;
        victim_age = '0;
        refreshed = 1'b0;
        for (i = 0; i < ENTRIES; i++) begin
          if (cache_valid[i] && key_match(i, r)) begin
            cache_stamp[i] = r.now;
            refreshed = 1'b1;
            break;
          end
          if (!cache_valid[i]) begin
            if (empty_slot < 0) empty_slot = i;
            continue;
          end
          age = r.now - cache_stamp[i];
          if (age > victim_age) begin
            victim = i;
            victim_age = age;
          end
        end
        if (!refreshed) begin
          if (empty_slot >= 0) victim = empty_slot;
          cache_zoom[victim] = r.zoom;
          cache_col[victim] = r.col;
          cache_row[victim] = r.row;
          cache_stamp[victim] = r.now;
          cache_valid[victim] = 1'b1;
        end
      end
      CMD_COUNT: begin
        if (lifetime_ms != 0) begin
          for (i = 0; i < ENTRIES; i++) begin
            if (!cache_valid[i]) continue;
            age = r.now - cache_stamp[i];
            if (age >= lifetime_ms) cache_valid[i] = 1'b0;
            else live++;
          end
          if (live > int'(COUNT_MAX)) live = int'(COUNT_MAX);
          a.live_count = live[COUNT_W-1:0];
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request side
  always @(negedge clk) begin
    lookup_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_drain && answers_due.size() == 0) tx_drain = 1'b0;
      if (tx_gap > 0 || tx_drain || req_queue.size() == 0) begin
        if (tx_gap > 0) tx_gap--;
        in_valid <= 1'b0;
      end else begin
        r = req_queue.pop_front();
        issued++;
        cmd <= r.cmd;
        zoom <= r.zoom;
        tile_x <= r.col;
        tile_y <= r.row;
        now_ms <= r.now;
        in_valid <= 1'b1;
        if (tx_free > 0) begin
          tx_free--;
          tx_gap = 0;
        end else if ($urandom_range(0, 99) < 5) begin
          tx_free = $urandom_range(20, 60);
          tx_gap = 0;
        end else begin
          tx_gap = ($urandom_range(0, 99) < 50) ? 0 : pick_gap();
        end
        // now and then hold back until every answer is in
        if ($urandom_range(0, 99) == 0) tx_drain = 1'b1;
      end
    end
  end

  // response side
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (answered >= next_long_hold) begin
        rx_wait = RX_LONG_HOLD;
        rx_free = 0;
        next_long_hold += 400;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else if (rx_free > 0) begin
        rx_free--;
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 8) begin
        rx_free = $urandom_range(30, 80);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 65) begin
        out_ready <= 1'b1;
      end else begin
        rx_wait = pick_gap() - 1;
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    answer_t a;
    answer_t got;
    if (!rst) begin
      if (ttl_ms_we) lifetime_ms = ttl_ms;
      if (out_valid && out_ready) begin
        answered++;
        got.hit = hit;
        got.live_count = live_count;
        if (answers_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected response hit=%0d live_count=%0d", $time, hit, live_count);
        end else begin
          a = answers_due.pop_front();
          if (got.hit !== a.hit) begin
            errors++;
            $display("%0t: hit mismatch, expected %0d, got %0d", $time, a.hit, got.hit);
          end
          if (got.live_count !== a.live_count) begin
            errors++;
            $display("%0t: live_count mismatch, expected %0d, got %0d",
                     $time, a.live_count, got.live_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_answer('{cmd, zoom, tile_x, tile_y, now_ms}, a);
        answers_due.push_back(a);
      end
    end
    in_taken <= !rst && in_valid && in_ready;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("ttl_negative_lookup_cache verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_req(input logic [CMD_W-1:0] c, input tile_key_t k,
                           input logic [TIME_W-1:0] t);
    req_queue.push_back('{c, k.zoom, k.col, k.row, t});
  endtask

  function automatic tile_key_t random_key();
    tile_key_t k;
    k.zoom = ZOOM_W'($urandom_range(0, 24));
    k.col = TILE_W'($urandom);
    k.row = TILE_W'($urandom);
    return k;
  endfunction

  task automatic queue_random(input int n);
    lookup_req_t r;
    tile_key_t k;
    int roll;
    logic [TIME_W-1:0] span;
    if (phase_ttl == 0) span = 500;
    else if (phase_ttl < 8) span = 3;
    else span = phase_ttl >> 2;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) r.cmd = CMD_QUERY;
      else if (roll < 80) r.cmd = CMD_RECORD;
      else if (roll < 96) r.cmd = CMD_COUNT;
      else r.cmd = CMD_UNUSED;
      if ($urandom_range(0, 99) < 75) k = key_pool[$urandom_range(0, KEY_POOL - 1)];
      else k = random_key();
      roll = $urandom_range(0, 99);
      // jump anywhere now and then, backwards included
      if (roll < 4) clock_ms = $urandom;
      else if (roll < 70) clock_ms += $urandom_range(0, span);
      r.zoom = k.zoom;
      r.col = k.col;
      r.row = k.row;
      r.now = clock_ms;
      req_queue.push_back(r);
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk); while (req_queue.size() != 0 || issued != answered);
    repeat (ENTRIES + 8) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [TIME_W-1:0] value);
    @(negedge clk);
    ttl_ms_we <= 1'b1;
    ttl_ms <= value;
    @(negedge clk);
    ttl_ms_we <= 1'b0;
    phase_ttl = value;
  endtask

  initial begin
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] ttl_plan [7];
    int i;
    key_pool[0] = '{5'd0, 24'h000000, 24'h000000};
    key_pool[1] = '{5'd24, 24'hFFFFFF, 24'hFFFFFF};
    key_pool[2] = '{5'd24, 24'hFFFFFF, 24'hFFFFFE};
    key_pool[3] = '{5'd23, 24'hFFFFFF, 24'hFFFFFF};
    key_pool[4] = '{5'd0, 24'h000001, 24'h000000};
    for (i = 5; i < KEY_POOL; i++) key_pool[i] = random_key();
    ttl_plan = '{32'd1000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd37, 32'h8000_0000, 32'd5000};
    phase_ttl = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // lifetime still zero from reset: query and count answer nothing
    t0 = 32'hFFFF_FF00;
    queue_req(CMD_RECORD, key_pool[0], t0);
    queue_req(CMD_QUERY, key_pool[0], t0);
    queue_req(CMD_COUNT, key_pool[0], t0);
    wait_quiet();

    write_ttl(32'd1000);
    queue_req(CMD_QUERY, key_pool[0], t0 + 10);
    // fill every slot at one time stamp across the wrap
    for (i = 1; i < ENTRIES; i++) queue_req(CMD_RECORD, key_pool[i], t0 + 300);
    queue_req(CMD_RECORD, key_pool[0], t0 + 300);
    // all ages zero: the newcomer takes slot 0
    queue_req(CMD_RECORD, key_pool[ENTRIES], t0 + 300);
    queue_req(CMD_QUERY, key_pool[0], t0 + 301);
    queue_req(CMD_QUERY, key_pool[2], t0 + 301);
    queue_req(CMD_COUNT, key_pool[0], t0 + 301);
    // refresh an expired entry, then hit on it
    queue_req(CMD_RECORD, key_pool[3], t0 + 1500);
    queue_req(CMD_QUERY, key_pool[3], t0 + 1501);
    queue_req(CMD_COUNT, key_pool[0], t0 + 1501);
    queue_req(CMD_UNUSED, key_pool[3], t0 + 1501);
    // time goes backwards: wrapped age is huge
    queue_req(CMD_QUERY, key_pool[3], t0 + 1400);
    queue_req(CMD_RECORD, key_pool[1], 32'hFFFF_FFFF);
    queue_req(CMD_COUNT, key_pool[1], 32'h0000_0000);
    wait_quiet();

    clock_ms = 32'hFFFF_F000;
    foreach (ttl_plan[p]) begin
      write_ttl(ttl_plan[p]);
      queue_random(145);
      wait_quiet();
    end

    if (answers_due.size() != 0) begin
      errors++;
      $display("%0t: %0d responses never arrived", $time, answers_due.size());
    end
    if (errors == 0) begin
      $display("ttl_negative_lookup_cache verification clean");
    end else begin
      $display("ttl_negative_lookup_cache verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/nlc_pkg.sv
hdl/nlc_ram.sv
hdl/nlc_ctrl.sv
hdl/nlc_dp.sv
hdl/ttl_negative_lookup_cache.sv
hdl/nlc_checker.sv
verif/tb_ttl_negative_lookup_cache.sv
